### sv/cau_pkg.sv
// Shared constants, codes and helper functions of the complex arithmetic unit.
// Used by the top level, the CORDIC pipeline and the checker.
// Depends on nothing.
`default_nettype none

package cau_pkg;

   localparam int WORD_BITS_DEF    = 32;
   localparam int FRAC_BITS_DEF    = 16;
   localparam int CORDIC_ITERS_DEF = 24;

   // operation codes
   localparam logic [3:0] OP_ADD       = 4'd0;
   localparam logic [3:0] OP_SUB       = 4'd1;
   localparam logic [3:0] OP_MUL       = 4'd2;
   localparam logic [3:0] OP_DIV       = 4'd3;
   localparam logic [3:0] OP_NEG       = 4'd4;
   localparam logic [3:0] OP_MAG       = 4'd5;
   localparam logic [3:0] OP_PHASE_RAD = 4'd6;
   localparam logic [3:0] OP_PHASE_DEG = 4'd7;
   localparam logic [3:0] OP_EQUAL     = 4'd8;
   localparam logic [3:0] OP_LESS      = 4'd9;

   // status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_DIV_ZERO = 2'd1;
   localparam logic [1:0] STATUS_SAT      = 2'd2;

   // CORDIC datapath widths: angle accumulator and vector components
   localparam int Z_BITS = 40;
   localparam int C_BITS = 44;

   // pi in Q32, 180/pi in Q20
   localparam logic signed [Z_BITS-1:0] PI_Q32      = 40'sd13493037704;
   localparam logic [25:0]              RAD2DEG_Q20 = 26'd60078979;

   typedef struct packed {
      logic [31:0] val;
      logic        flag;
   } sat_type;

   // atan(2^-i) in Q32
   function automatic logic [32:0] atan_step(input int unsigned i);
      logic [32:0] r;
      case (i)
         0:       r = 33'd3373259426;
         1:       r = 33'd1991351318;
         2:       r = 33'd1052175346;
         3:       r = 33'd534100635;
         4:       r = 33'd268086748;
         5:       r = 33'd134174063;
         6:       r = 33'd67103403;
         7:       r = 33'd33553749;
         8:       r = 33'd16777131;
         9:       r = 33'd8388597;
         10:      r = 33'd4194303;
         11:      r = 33'd2097152;
         default: r = (i <= 32) ? (33'd1 << (32 - i)) : 33'd0;
      endcase
      return r;
   endfunction

   // clamp a wide signed value to a signed word of w bits (w at most 32)
   function automatic sat_type saturate(input logic signed [71:0] v, input int unsigned w);
      logic signed [71:0] hi;
      logic signed [71:0] lo;
      sat_type            r;
      hi = (72'sd1 <<< (w - 1)) - 72'sd1;
      lo = -hi - 72'sd1;
      if (v > hi) begin
         r.val  = hi[31:0];
         r.flag = 1'b1;
      end else if (v < lo) begin
         r.val  = lo[31:0];
         r.flag = 1'b1;
      end else begin
         r.val  = v[31:0];
         r.flag = 1'b0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/cau_div_pipe.sv
// Restoring divider pipeline, one quotient bit per stage.
// Depends on nothing from the package.
`default_nettype none

module cau_div_pipe #(
   parameter int STEPS = 80
) (
   input  wire logic        clock,
   input  wire logic [63:0] num,
   input  wire logic [63:0] den,
   input  wire logic        neg,
   output logic      [32:0] quot,
   output logic             ovf,
   output logic             neg_out
);

   logic [63:0] num_ff [1:STEPS];
   logic [63:0] den_ff [1:STEPS];
   logic [63:0] rem_ff [1:STEPS];
   logic [32:0] q_ff   [1:STEPS];
   logic        ovf_ff [1:STEPS];
   logic        neg_ff [1:STEPS];

   logic [63:0] num_in [1:STEPS];
   logic [63:0] den_in [1:STEPS];
   logic [63:0] rem_in [1:STEPS];
   logic [32:0] q_in   [1:STEPS];
   logic        ovf_in [1:STEPS];
   logic        neg_in [1:STEPS];

   always_comb begin
      logic [63:0] pn;
      logic [63:0] pd;
      logic [63:0] pr;
      logic [32:0] pq;
      logic        po;
      logic        pg;
      logic [64:0] r2;
      logic        ge;
      for (int j = 1; j <= STEPS; j++) begin
         if (j == 1) begin
            pn = num;
            pd = den;
            pr = '0;
            pq = '0;
            po = 1'b0;
            pg = neg;
         end else begin
            pn = num_ff[j-1];
            pd = den_ff[j-1];
            pr = rem_ff[j-1];
            pq = q_ff[j-1];
            po = ovf_ff[j-1];
            pg = neg_ff[j-1];
         end
         // bring down the next numerator bit, zeros after the last one
         r2 = {pr, pn[63]};
         ge = (r2 >= {1'b0, pd});
         rem_in[j] = ge ? 64'(r2 - {1'b0, pd}) : r2[63:0];
         num_in[j] = {pn[62:0], 1'b0};
         den_in[j] = pd;
         q_in[j]   = {pq[31:0], ge};
         ovf_in[j] = po | pq[32];
         neg_in[j] = pg;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 1; j <= STEPS; j++) begin
         num_ff[j] <= num_in[j];
         den_ff[j] <= den_in[j];
         rem_ff[j] <= rem_in[j];
         q_ff[j]   <= q_in[j];
         ovf_ff[j] <= ovf_in[j];
         neg_ff[j] <= neg_in[j];
      end
   end

   assign quot    = q_ff[STEPS];
   assign ovf     = ovf_ff[STEPS];
   assign neg_out = neg_ff[STEPS];

endmodule

`default_nettype wire

### sv/cau_cordic_pipe.sv
// Vectoring CORDIC pipeline giving atan2(y, x) in Q32 radians.
// Depends on cau_pkg (angle table, pi, datapath widths).
`default_nettype none

module cau_cordic_pipe #(
   parameter int ITERS = 24
) (
   input  wire logic                               clock,
   input  wire logic signed [31:0]                 x_in,
   input  wire logic signed [31:0]                 y_in,
   output logic signed      [cau_pkg::Z_BITS-1:0]  z_out
);

   localparam int ZW = cau_pkg::Z_BITS;
   localparam int CW = cau_pkg::C_BITS;

   // pre stage 1: fold into the right half plane
   logic signed [32:0]   p1_x_ff, p1_y_ff;
   logic signed [ZW-1:0] p1_z_ff;
   logic                 p1_yz_ff, p1_xn_ff;
   // pre stage 2: largest component
   logic signed [32:0]   p2_x_ff, p2_y_ff;
   logic signed [ZW-1:0] p2_z_ff;
   logic                 p2_yz_ff, p2_xn_ff;
   logic [32:0]          p2_m_ff;
   // pre stage 3: normalizing shift amount
   logic signed [32:0]   p3_x_ff, p3_y_ff;
   logic signed [ZW-1:0] p3_z_ff;
   logic                 p3_yz_ff, p3_xn_ff;
   logic [5:0]           p3_sh_ff;

   logic [32:0] abs_y;
   logic [5:0]  bits;

   logic signed [CW-1:0] cx_ff [0:ITERS];
   logic signed [CW-1:0] cy_ff [0:ITERS];
   logic signed [ZW-1:0] cz_ff [0:ITERS];
   logic                 yz_ff [0:ITERS];
   logic                 xn_ff [0:ITERS];

   logic signed [CW-1:0] cx_in [1:ITERS];
   logic signed [CW-1:0] cy_in [1:ITERS];
   logic signed [ZW-1:0] cz_in [1:ITERS];

   always_comb begin
      abs_y = p1_y_ff[32] ? 33'(-p1_y_ff) : 33'(p1_y_ff);
      bits  = '0;
      for (int i = 0; i < 33; i++) begin
         if (p2_m_ff[i]) bits = 6'(i + 1);
      end
   end

   always_comb begin
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [ZW-1:0] a;
      for (int i = 0; i < ITERS; i++) begin
         dx = cy_ff[i] >>> i;
         dy = cx_ff[i] >>> i;
         a  = $signed({{(ZW-33){1'b0}}, cau_pkg::atan_step(i)});
         if (cy_ff[i] > 0) begin
            cx_in[i+1] = cx_ff[i] + dx;
            cy_in[i+1] = cy_ff[i] - dy;
            cz_in[i+1] = cz_ff[i] + a;
         end else begin
            cx_in[i+1] = cx_ff[i] - dx;
            cy_in[i+1] = cy_ff[i] + dy;
            cz_in[i+1] = cz_ff[i] - a;
         end
      end
   end

   always_ff @(posedge clock) begin
      p1_yz_ff <= (y_in == 32'sd0);
      p1_xn_ff <= x_in[31];
      if (x_in[31]) begin
         p1_x_ff <= -33'(x_in);
         p1_y_ff <= -33'(y_in);
         p1_z_ff <= (y_in > 32'sd0) ? cau_pkg::PI_Q32 : -cau_pkg::PI_Q32;
      end else begin
         p1_x_ff <= 33'(x_in);
         p1_y_ff <= 33'(y_in);
         p1_z_ff <= '0;
      end

      p2_x_ff  <= p1_x_ff;
      p2_y_ff  <= p1_y_ff;
      p2_z_ff  <= p1_z_ff;
      p2_yz_ff <= p1_yz_ff;
      p2_xn_ff <= p1_xn_ff;
      p2_m_ff  <= (33'(p1_x_ff) > abs_y) ? 33'(p1_x_ff) : abs_y;

      p3_x_ff  <= p2_x_ff;
      p3_y_ff  <= p2_y_ff;
      p3_z_ff  <= p2_z_ff;
      p3_yz_ff <= p2_yz_ff;
      p3_xn_ff <= p2_xn_ff;
      p3_sh_ff <= 6'd40 - bits;

      cx_ff[0] <= CW'(p3_x_ff) <<< p3_sh_ff;
      cy_ff[0] <= CW'(p3_y_ff) <<< p3_sh_ff;
      cz_ff[0] <= p3_z_ff;
      yz_ff[0] <= p3_yz_ff;
      xn_ff[0] <= p3_xn_ff;

      for (int j = 1; j <= ITERS; j++) begin
         cx_ff[j] <= cx_in[j];
         cy_ff[j] <= cy_in[j];
         cz_ff[j] <= cz_in[j];
         yz_ff[j] <= yz_ff[j-1];
         xn_ff[j] <= xn_ff[j-1];
      end
   end

   // on the real axis the angle is 0 or +pi outright
   assign z_out = yz_ff[ITERS] ? (xn_ff[ITERS] ? cau_pkg::PI_Q32 : '0) : cz_ff[ITERS];

endmodule

`default_nettype wire

### sv/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit: operand pipeline, products, square root
// and result merge. Depends on cau_pkg, cau_div_pipe and cau_cordic_pipe.
`default_nettype none

// The unit takes one operation per clock: an item transfers on any edge where
// start is high, and busy is always low. Every item gives exactly one result,
// shown for a single cycle with rsp_valid high; results leave in the order the
// items came. The depth of the result lane is set by the restoring divider,
// which resolves one quotient bit per stage over 64 + FRAC_BITS stages. Results
// cannot be held off, so capture them the cycle rsp_valid is high. Arithmetic
// results saturate to WORD_BITS bits, at most 32 (status 2); a zero divisor
// gives zero with status 1.

module complex_arithmetic_unit #(
   parameter int WORD_BITS    = cau_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS    = cau_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_ITERS = cau_pkg::CORDIC_ITERS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [3:0]         req_operation,
   input  wire logic signed [31:0] req_a_re,
   input  wire logic signed [31:0] req_a_im,
   input  wire logic signed [31:0] req_b_re,
   input  wire logic signed [31:0] req_b_im,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_res_re,
   output logic signed [31:0]      rsp_res_im,
   output logic                    rsp_compare_true,
   output logic [1:0]              rsp_status
);

   localparam int SAT_W     = (WORD_BITS > 32) ? 32 : WORD_BITS;
   localparam int DIV_STEPS = 64 + FRAC_BITS;
   localparam int LAT       = 6 + DIV_STEPS;
   // lane stage at which each path writes its result
   localparam int SIMPLE_K  = 2;
   localparam int MUL_K     = 5;
   localparam int SQRT_K    = 37;
   localparam int RAD_K     = 6 + CORDIC_ITERS;
   localparam int DEG_K     = 7 + CORDIC_ITERS;
   localparam int ZW        = cau_pkg::Z_BITS;

   typedef struct packed {
      logic [31:0] re;
      logic [31:0] im;
      logic        cmp;
      logic        sat;
      logic        dz;
   } res_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] op;
      res_type    res;
   } lane_type;

   // result lane: op and partial result travel with the item
   lane_type lane_ff [1:LAT];
   lane_type lane_in [1:LAT];

   // stage 1: operands
   logic signed [31:0] ar_ff, ai_ff, br_ff, bi_ff;
   // stage 2: magnitudes and signs
   logic [31:0] mar_ff, mai_ff, mbr_ff, mbi_ff;
   logic        sar_ff, sai_ff, sbr_ff, sbi_ff;
   // stage 3: products of magnitudes, product signs
   logic [63:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic [63:0] p_bbr_ff, p_bbi_ff, p_aar_ff, p_aai_ff;
   logic        n_rr_ff, n_ii_ff, n_ri_ff, n_ir_ff;
   // stage 4: signed sums
   logic signed [65:0] mul_re_ff, mul_im_ff, dsum_re_ff, dsum_im_ff;
   logic [63:0]        den_ff;
   // stage 5: divider operands
   logic [63:0] dnum_re_ff, dnum_im_ff, dden_ff;
   logic        dneg_re_ff, dneg_im_ff;

   // square root, one result bit per stage; entry 0 is stage 4
   logic [63:0] sq_r_ff   [0:32];
   logic [63:0] sq_rem_ff [0:32];
   logic [63:0] sq_r_in   [1:32];
   logic [63:0] sq_rem_in [1:32];

   logic signed [ZW-1:0] cor_z;
   logic signed [ZW+26:0] deg_prod_ff;

   logic [32:0] dq_re, dq_im;
   logic        dovf_re, dovf_im, dng_re, dng_im;

   logic signed [32:0] add_re, add_im, sub_re, sub_im, neg_re, neg_im;

   assign busy = 1'b0;

   // ---------------- arithmetic datapath ----------------

   function automatic logic signed [65:0] sgn66(input logic n, input logic [63:0] m);
      logic signed [65:0] v;
      v = $signed({2'b00, m});
      return n ? -v : v;
   endfunction

   always_ff @(posedge clock) begin
      ar_ff <= req_a_re;
      ai_ff <= req_a_im;
      br_ff <= req_b_re;
      bi_ff <= req_b_im;

      // magnitudes fit 32 unsigned bits, the most negative word included
      mar_ff <= ar_ff[31] ? 32'(-ar_ff) : 32'(ar_ff);
      mai_ff <= ai_ff[31] ? 32'(-ai_ff) : 32'(ai_ff);
      mbr_ff <= br_ff[31] ? 32'(-br_ff) : 32'(br_ff);
      mbi_ff <= bi_ff[31] ? 32'(-bi_ff) : 32'(bi_ff);
      sar_ff <= ar_ff[31];
      sai_ff <= ai_ff[31];
      sbr_ff <= br_ff[31];
      sbi_ff <= bi_ff[31];

      p_rr_ff  <= mar_ff * mbr_ff;
      p_ii_ff  <= mai_ff * mbi_ff;
      p_ri_ff  <= mar_ff * mbi_ff;
      p_ir_ff  <= mai_ff * mbr_ff;
      p_bbr_ff <= mbr_ff * mbr_ff;
      p_bbi_ff <= mbi_ff * mbi_ff;
      p_aar_ff <= mar_ff * mar_ff;
      p_aai_ff <= mai_ff * mai_ff;
      n_rr_ff  <= sar_ff ^ sbr_ff;
      n_ii_ff  <= sai_ff ^ sbi_ff;
      n_ri_ff  <= sar_ff ^ sbi_ff;
      n_ir_ff  <= sai_ff ^ sbr_ff;

      mul_re_ff  <= sgn66(n_rr_ff, p_rr_ff) - sgn66(n_ii_ff, p_ii_ff);
      mul_im_ff  <= sgn66(n_ri_ff, p_ri_ff) + sgn66(n_ir_ff, p_ir_ff);
      dsum_re_ff <= sgn66(n_rr_ff, p_rr_ff) + sgn66(n_ii_ff, p_ii_ff);
      dsum_im_ff <= sgn66(n_ir_ff, p_ir_ff) - sgn66(n_ri_ff, p_ri_ff);
      den_ff     <= p_bbr_ff + p_bbi_ff;
      sq_rem_ff[0] <= p_aar_ff + p_aai_ff;
      sq_r_ff[0]   <= '0;

      dneg_re_ff <= dsum_re_ff[65];
      dneg_im_ff <= dsum_im_ff[65];
      dnum_re_ff <= dsum_re_ff[65] ? 64'(-dsum_re_ff) : dsum_re_ff[63:0];
      dnum_im_ff <= dsum_im_ff[65] ? 64'(-dsum_im_ff) : dsum_im_ff[63:0];
      dden_ff    <= den_ff;

      for (int j = 1; j <= 32; j++) begin
         sq_r_ff[j]   <= sq_r_in[j];
         sq_rem_ff[j] <= sq_rem_in[j];
      end

      deg_prod_ff <= cor_z * $signed({1'b0, cau_pkg::RAD2DEG_Q20});
   end

   // digit-by-digit square root, trial bit 4^(32-j) at stage j
   always_comb begin
      logic [63:0] bitv;
      logic [64:0] trial;
      for (int j = 1; j <= 32; j++) begin
         bitv  = 64'd1 << (62 - 2 * (j - 1));
         trial = {1'b0, sq_r_ff[j-1]} + {1'b0, bitv};
         if ({1'b0, sq_rem_ff[j-1]} >= trial) begin
            sq_rem_in[j] = sq_rem_ff[j-1] - trial[63:0];
            sq_r_in[j]   = (sq_r_ff[j-1] >> 1) + bitv;
         end else begin
            sq_rem_in[j] = sq_rem_ff[j-1];
            sq_r_in[j]   = sq_r_ff[j-1] >> 1;
         end
      end
   end

   cau_div_pipe #(
      .STEPS (DIV_STEPS)
   ) u_div_re (
      .clock   (clock),
      .num     (dnum_re_ff),
      .den     (dden_ff),
      .neg     (dneg_re_ff),
      .quot    (dq_re),
      .ovf     (dovf_re),
      .neg_out (dng_re)
   );

   cau_div_pipe #(
      .STEPS (DIV_STEPS)
   ) u_div_im (
      .clock   (clock),
      .num     (dnum_im_ff),
      .den     (dden_ff),
      .neg     (dneg_im_ff),
      .quot    (dq_im),
      .ovf     (dovf_im),
      .neg_out (dng_im)
   );

   cau_cordic_pipe #(
      .ITERS (CORDIC_ITERS)
   ) u_cordic (
      .clock (clock),
      .x_in  (ar_ff),
      .y_in  (ai_ff),
      .z_out (cor_z)
   );

   assign add_re = 33'(ar_ff) + 33'(br_ff);
   assign add_im = 33'(ai_ff) + 33'(bi_ff);
   assign sub_re = 33'(ar_ff) - 33'(br_ff);
   assign sub_im = 33'(ai_ff) - 33'(bi_ff);
   assign neg_re = -33'(ar_ff);
   assign neg_im = -33'(ai_ff);

   // ---------------- result lane ----------------

   always_comb begin
      cau_pkg::sat_type   t_re;
      cau_pkg::sat_type   t_im;
      logic signed [71:0] v_re;
      logic signed [71:0] v_im;

      t_re = '0;
      t_im = '0;
      v_re = '0;
      v_im = '0;

      lane_in[1].valid = start & ~busy;
      lane_in[1].op    = req_operation;
      lane_in[1].res   = '0;
      for (int k = 2; k <= LAT; k++) begin
         lane_in[k] = lane_ff[k-1];
      end

      // add, subtract, negate and the comparisons settle at once
      case (lane_ff[SIMPLE_K-1].op)
         cau_pkg::OP_ADD: begin
            t_re = cau_pkg::saturate($signed({{39{add_re[32]}}, add_re}), SAT_W);
            t_im = cau_pkg::saturate($signed({{39{add_im[32]}}, add_im}), SAT_W);
            lane_in[SIMPLE_K].res.re  = t_re.val;
            lane_in[SIMPLE_K].res.im  = t_im.val;
            lane_in[SIMPLE_K].res.sat = t_re.flag | t_im.flag;
         end
         cau_pkg::OP_SUB: begin
            t_re = cau_pkg::saturate($signed({{39{sub_re[32]}}, sub_re}), SAT_W);
            t_im = cau_pkg::saturate($signed({{39{sub_im[32]}}, sub_im}), SAT_W);
            lane_in[SIMPLE_K].res.re  = t_re.val;
            lane_in[SIMPLE_K].res.im  = t_im.val;
            lane_in[SIMPLE_K].res.sat = t_re.flag | t_im.flag;
         end
         cau_pkg::OP_NEG: begin
            t_re = cau_pkg::saturate($signed({{39{neg_re[32]}}, neg_re}), SAT_W);
            t_im = cau_pkg::saturate($signed({{39{neg_im[32]}}, neg_im}), SAT_W);
            lane_in[SIMPLE_K].res.re  = t_re.val;
            lane_in[SIMPLE_K].res.im  = t_im.val;
            lane_in[SIMPLE_K].res.sat = t_re.flag | t_im.flag;
         end
         cau_pkg::OP_EQUAL: begin
            lane_in[SIMPLE_K].res.cmp = (ar_ff == br_ff) && (ai_ff == bi_ff);
         end
         cau_pkg::OP_LESS: begin
            lane_in[SIMPLE_K].res.cmp = (ar_ff < br_ff) || ((ar_ff == br_ff) && (ai_ff < bi_ff));
         end
         default: begin
         end
      endcase

      // multiply: round half up, drop the fraction, clamp
      if (lane_ff[MUL_K-1].op == cau_pkg::OP_MUL) begin
         v_re = $signed({{6{mul_re_ff[65]}}, mul_re_ff});
         v_im = $signed({{6{mul_im_ff[65]}}, mul_im_ff});
         v_re = (v_re + (72'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
         v_im = (v_im + (72'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
         t_re = cau_pkg::saturate(v_re, SAT_W);
         t_im = cau_pkg::saturate(v_im, SAT_W);
         lane_in[MUL_K].res.re  = t_re.val;
         lane_in[MUL_K].res.im  = t_im.val;
         lane_in[MUL_K].res.sat = t_re.flag | t_im.flag;
      end
      if ((lane_ff[MUL_K-1].op == cau_pkg::OP_DIV) && (den_ff == 64'd0)) begin
         lane_in[MUL_K].res.dz = 1'b1;
      end

      // magnitude: round when the remainder passes the root
      if (lane_ff[SQRT_K-1].op == cau_pkg::OP_MAG) begin
         v_re = $signed({8'd0, sq_r_ff[32]});
         if (sq_rem_ff[32] > sq_r_ff[32]) v_re = v_re + 72'sd1;
         t_re = cau_pkg::saturate(v_re, SAT_W);
         lane_in[SQRT_K].res.re  = t_re.val;
         lane_in[SQRT_K].res.sat = t_re.flag;
      end

      if (lane_ff[RAD_K-1].op == cau_pkg::OP_PHASE_RAD) begin
         v_re = $signed({{(72-ZW){cor_z[ZW-1]}}, cor_z});
         v_re = (v_re + (72'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
         t_re = cau_pkg::saturate(v_re, SAT_W);
         lane_in[RAD_K].res.re  = t_re.val;
         lane_in[RAD_K].res.sat = t_re.flag;
      end

      if (lane_ff[DEG_K-1].op == cau_pkg::OP_PHASE_DEG) begin
         v_re = $signed({{(72-ZW-27){deg_prod_ff[ZW+26]}}, deg_prod_ff});
         v_re = (v_re + (72'sd1 <<< (51 - FRAC_BITS))) >>> (52 - FRAC_BITS);
         t_re = cau_pkg::saturate(v_re, SAT_W);
         lane_in[DEG_K].res.re  = t_re.val;
         lane_in[DEG_K].res.sat = t_re.flag;
      end

      // divide: a quotient past 2^32 only needs to clamp
      if ((lane_ff[LAT-1].op == cau_pkg::OP_DIV) && !lane_ff[LAT-1].res.dz) begin
         v_re = dovf_re ? (72'sd1 <<< 40) : $signed({39'd0, dq_re});
         v_im = dovf_im ? (72'sd1 <<< 40) : $signed({39'd0, dq_im});
         if (dng_re) v_re = -v_re;
         if (dng_im) v_im = -v_im;
         t_re = cau_pkg::saturate(v_re, SAT_W);
         t_im = cau_pkg::saturate(v_im, SAT_W);
         lane_in[LAT].res.re  = t_re.val;
         lane_in[LAT].res.im  = t_im.val;
         lane_in[LAT].res.sat = t_re.flag | t_im.flag;
      end
   end

   // advance the lane; drop everything in flight on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= LAT; k++) begin
            lane_ff[k] <= '0;
         end
      end else begin
         for (int k = 1; k <= LAT; k++) begin
            lane_ff[k] <= lane_in[k];
         end
      end
   end

   // drive the result ports from the last lane stage
   assign rsp_valid        = lane_ff[LAT].valid;
   assign rsp_res_re       = lane_ff[LAT].res.re;
   assign rsp_res_im       = lane_ff[LAT].res.im;
   assign rsp_compare_true = lane_ff[LAT].res.cmp;
   assign rsp_status       = lane_ff[LAT].res.dz  ? cau_pkg::STATUS_DIV_ZERO :
                             lane_ff[LAT].res.sat ? cau_pkg::STATUS_SAT : cau_pkg::STATUS_OK;

endmodule

`default_nettype wire

### sv/cau_checker.sv
// Port-level assertions for the complex arithmetic unit, bound to the top level.
// Depends on cau_pkg (status codes).
`default_nettype none

module cau_assertions (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [31:0] rsp_res_re,
   input wire logic [31:0] rsp_res_im,
   input wire logic        rsp_compare_true,
   input wire logic [1:0]  rsp_status
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result transfer right after reset");

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == cau_pkg::STATUS_DIV_ZERO))
      |-> (rsp_res_re == 32'd0) && (rsp_res_im == 32'd0) && !rsp_compare_true)
      else $error("divide by zero result not cleared");

   a_compare_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_compare_true)
      |-> (rsp_res_re == 32'd0) && (rsp_res_im == 32'd0) && (rsp_status == cau_pkg::STATUS_OK))
      else $error("comparison result carries data or status");

endmodule

bind complex_arithmetic_unit cau_assertions u_cau_checker (
   .clock            (clock),
   .reset            (reset),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_res_re       (rsp_res_re),
   .rsp_res_im       (rsp_res_im),
   .rsp_compare_true (rsp_compare_true),
   .rsp_status       (rsp_status)
);

`default_nettype wire

### tb/sv/cau_checker.sv
// Checker of the complex arithmetic unit: watches input and result transfers,
// predicts each result and compares it field by field. Depends on cau_pkg.
`default_nettype none

module cau_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic [3:0]         req_operation,
   input  wire logic signed [31:0] req_a_re,
   input  wire logic signed [31:0] req_a_im,
   input  wire logic signed [31:0] req_b_re,
   input  wire logic signed [31:0] req_b_im,
   input  wire logic               rsp_valid,
   input  wire logic signed [31:0] rsp_res_re,
   input  wire logic signed [31:0] rsp_res_im,
   input  wire logic               rsp_compare_true,
   input  wire logic [1:0]         rsp_status,
   output int                      fail_count,
   output int                      pending_count
);

   localparam int FRAC = cau_pkg::FRAC_BITS_DEF;
   localparam int ITERS = cau_pkg::CORDIC_ITERS_DEF;
   localparam longint RAD2DEG = 64'sd60078979;
   localparam longint PI_VAL = 64'sd13493037704;

   typedef struct {
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic               cmp;
      logic [1:0]         st;
   } cplx_result_type;

   cplx_result_type result_fifo[$];
   longint          stamp = 0;
   int              fails = 0;

   assign pending_count = result_fifo.size();
   assign fail_count = fails;

   function automatic longint shr_floor(longint x, int s);
      return x >>> s;
   endfunction

   function automatic longint clamp_word(longint v, ref bit ovf);
      if (v > 64'sd2147483647) begin
         ovf = 1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         ovf = 1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // sum of two signed products as sign and 64-bit magnitude
   function automatic void signed_prod_sum(longint p, longint q, longint r, longint s,
                                           ref bit neg, ref logic [63:0] m);
      logic [63:0] m1, m2;
      bit n1, n2;
      m1 = 64'((p < 0 ? -p : p) * (q < 0 ? -q : q));
      m2 = 64'((r < 0 ? -r : r) * (s < 0 ? -s : s));
      n1 = (p < 0) != (q < 0);
      n2 = (r < 0) != (s < 0);
      if (m1 == 0) n1 = 0;
      if (m2 == 0) n2 = 0;
      if (n1 == n2) begin
         neg = n1;
         m = m1 + m2;
      end else if (m1 >= m2) begin
         neg = n1;
         m = m1 - m2;
      end else begin
         neg = n2;
         m = m2 - m1;
      end
   endfunction

   // restoring division with FRAC extra bits; quotient held at 2^40
   function automatic longint quotient(bit neg, logic [63:0] num, logic [63:0] den,
                                       ref bit ovf);
      logic [64:0] rem;
      logic [63:0] q;
      logic [63:0] cap;
      rem = 0;
      q = 0;
      cap = 64'd1 << 40;
      for (int i = 0; i < 64 + FRAC; i++) begin
         rem = {rem[63:0], (i < 64) ? num[63 - i] : 1'b0};
         if (q < cap) q = q << 1;
         if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            if (q < cap) q[0] = 1'b1;
         end
      end
      if (q > cap) q = cap;
      return clamp_word(neg ? -longint'(q) : longint'(q), ovf);
   endfunction

   function automatic logic [63:0] root_nearest(logic [63:0] n);
      logic [63:0] r, bitv, rem;
      r = 0;
      bitv = 64'd1 << 62;
      rem = n;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= r + bitv) begin
            rem = rem - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      if (rem > r) r++;
      return r;
   endfunction

   // atan2 with 32 fraction bits by CORDIC vectoring
   function automatic longint angle_q32(longint x, longint y);
      longint z, m, ay, dx, dy;
      int nb;
      z = 0;
      nb = 0;
      if (y == 0) return (x < 0) ? PI_VAL : 0;
      if (x < 0) begin
         z = (y > 0) ? PI_VAL : -PI_VAL;
         x = -x;
         y = -y;
      end
      ay = (y < 0) ? -y : y;
      m = (x > ay) ? x : ay;
      while (nb < 63 && (m >>> nb) != 0) nb++;
      x = x <<< (40 - nb);
      y = y <<< (40 - nb);
      for (int i = 0; i < ITERS; i++) begin
         dx = shr_floor(y, i);
         dy = shr_floor(x, i);
         if (y > 0) begin
            x += dx;
            y -= dy;
            z += longint'(cau_pkg::atan_step(i));
         end else begin
            x -= dx;
            y += dy;
            z -= longint'(cau_pkg::atan_step(i));
         end
      end
      return z;
   endfunction

   function automatic cplx_result_type predict_result(logic [3:0] op, longint ar, longint ai,
                                                      longint br, longint bi);
      cplx_result_type r;
      bit ovf, neg;
      longint rr, ri, half, z;
      logic [63:0] den, m;
      ovf = 0;
      rr = 0;
      ri = 0;
      half = 64'sd1 <<< (FRAC - 1);
      r.cmp = 0;
      r.st = cau_pkg::STATUS_OK;
      case (op)
         cau_pkg::OP_ADD: begin
            rr = clamp_word(ar + br, ovf);
            ri = clamp_word(ai + bi, ovf);
         end
         cau_pkg::OP_SUB: begin
            rr = clamp_word(ar - br, ovf);
            ri = clamp_word(ai - bi, ovf);
         end
         cau_pkg::OP_MUL: begin
            rr = clamp_word(shr_floor(ar * br - ai * bi + half, FRAC), ovf);
            ri = clamp_word(shr_floor(ar * bi + ai * br + half, FRAC), ovf);
         end
         cau_pkg::OP_DIV: begin
            den = 64'(br * br) + 64'(bi * bi);
            if (den == 0) begin
               r.st = cau_pkg::STATUS_DIV_ZERO;
            end else begin
               signed_prod_sum(ar, br, ai, bi, neg, m);
               rr = quotient(neg, m, den, ovf);
               signed_prod_sum(ai, br, -ar, bi, neg, m);
               ri = quotient(neg, m, den, ovf);
            end
         end
         cau_pkg::OP_NEG: begin
            rr = clamp_word(-ar, ovf);
            ri = clamp_word(-ai, ovf);
         end
         cau_pkg::OP_MAG:
            rr = clamp_word(longint'(root_nearest(64'(ar * ar) + 64'(ai * ai))), ovf);
         cau_pkg::OP_PHASE_RAD: begin
            z = angle_q32(ar, ai);
            rr = clamp_word(shr_floor(z + (64'sd1 <<< (31 - FRAC)), 32 - FRAC), ovf);
         end
         cau_pkg::OP_PHASE_DEG: begin
            z = angle_q32(ar, ai);
            rr = clamp_word(shr_floor(z * RAD2DEG + (64'sd1 <<< (51 - FRAC)), 52 - FRAC),
                            ovf);
         end
         cau_pkg::OP_EQUAL: r.cmp = (ar == br && ai == bi);
         cau_pkg::OP_LESS: r.cmp = (ar < br || (ar == br && ai < bi));
         default: ;
      endcase
      if (ovf && r.st == cau_pkg::STATUS_OK) r.st = cau_pkg::STATUS_SAT;
      r.re = rr[31:0];
      r.im = ri[31:0];
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", stamp, field, got, want);
      fails++;
   endtask

   always @(posedge clock) begin
      cplx_result_type want;
      stamp <= stamp + 1;
      if (!reset) begin
         if (start && !busy)
            result_fifo.push_back(predict_result(req_operation, req_a_re, req_a_im,
                                                 req_b_re, req_b_im));
         if (rsp_valid) begin
            if (result_fifo.size() == 0) begin
               report_mismatch("unexpected result, res_re", rsp_res_re, 0);
            end else begin
               want = result_fifo.pop_front();
               if (rsp_res_re !== want.re) report_mismatch("res_re", rsp_res_re, want.re);
               if (rsp_res_im !== want.im) report_mismatch("res_im", rsp_res_im, want.im);
               if (rsp_compare_true !== want.cmp)
                  report_mismatch("compare_true", rsp_compare_true, want.cmp);
               if (rsp_status !== want.st) report_mismatch("status", rsp_status, want.st);
            end
         end
      end
   end

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Top of the complex arithmetic unit testbench: clock, reset, stimulus, verdict.
// Depends on cau_pkg, complex_arithmetic_unit and cau_checker.
`default_nettype none

module testbench;

   localparam int LATENCY = 70 + cau_pkg::FRAC_BITS_DEF;
   localparam int RANDOM_ITEMS = 1530;
   localparam longint CYCLE_LIMIT = 400000;

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic [3:0]         req_operation = '0;
   logic signed [31:0] req_a_re = '0;
   logic signed [31:0] req_a_im = '0;
   logic signed [31:0] req_b_re = '0;
   logic signed [31:0] req_b_im = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_res_re;
   logic signed [31:0] rsp_res_im;
   logic               rsp_compare_true;
   logic [1:0]         rsp_status;
   int                 fail_count;
   int                 pending_count;
   longint             cycle_count = 0;

   always #5 clock = ~clock;

   complex_arithmetic_unit u_dut (
      .clock, .reset, .start, .busy, .req_operation, .req_a_re, .req_a_im,
      .req_b_re, .req_b_im, .rsp_valid, .rsp_res_re, .rsp_res_im,
      .rsp_compare_true, .rsp_status
   );

   cau_checker u_checker (
      .clock, .reset, .start, .busy, .req_operation, .req_a_re, .req_a_im,
      .req_b_re, .req_b_im, .rsp_valid, .rsp_res_re, .rsp_res_im,
      .rsp_compare_true, .rsp_status, .fail_count, .pending_count
   );

   // hard stop on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // pick an operand value: extremes, small Q16.16 numbers, or raw noise
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return '0;
         3: return 32'($signed($urandom_range(0, 20)) - 10) <<< 16;
         4, 5: return 32'($signed($urandom_range(0, 200000)) - 100000);
         6: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   // hold one item on the request ports until it transfers, then drop start
   // unless another item follows at once
   task automatic send_item(logic [3:0] op, logic [31:0] ar, logic [31:0] ai,
                            logic [31:0] br, logic [31:0] bi, bit idle_after);
      start <= 1'b1;
      req_operation <= op;
      req_a_re <= ar;
      req_a_im <= ai;
      req_b_re <= br;
      req_b_im <= bi;
      do @(posedge clock); while (busy);
      if (idle_after) begin
         start <= 1'b0;
         req_operation <= 4'($urandom);
         req_a_re <= $urandom;
      end
   endtask

   function automatic bit want_gap();
      return $urandom_range(0, 3) == 0;
   endfunction

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      repeat (n) @(posedge clock);
   endtask

   initial begin
      logic [31:0] ar, ai, br, bi;
      logic [3:0]  op;
      bit          gap;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every operation, extremes, zero divisor, phase of zero and
      // of the negative real axis, unused codes
      send_item(cau_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF, 1);
      idle_gap();
      send_item(cau_pkg::OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF, 0);
      send_item(cau_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 0);
      send_item(cau_pkg::OP_MUL, 32'h0001_8000, 32'h0, 32'h0000_8000, 32'h0, 0);
      send_item(cau_pkg::OP_DIV, 32'h0003_0000, 32'h0001_0000, 32'h0, 32'h0, 0);
      send_item(cau_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h0, 0);
      send_item(cau_pkg::OP_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                32'hFFFF_0000, 0);
      send_item(cau_pkg::OP_NEG, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 0);
      send_item(cau_pkg::OP_MAG, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 0);
      send_item(cau_pkg::OP_MAG, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0, 0);
      send_item(cau_pkg::OP_PHASE_RAD, 32'h0, 32'h0, 32'h0, 32'h0, 0);
      send_item(cau_pkg::OP_PHASE_RAD, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 0);
      send_item(cau_pkg::OP_PHASE_DEG, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 0);
      send_item(cau_pkg::OP_PHASE_DEG, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0, 0);
      send_item(cau_pkg::OP_PHASE_RAD, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 0);
      send_item(cau_pkg::OP_EQUAL, 32'h1234_5678, 32'h8000_0000, 32'h1234_5678,
                32'h8000_0000, 0);
      send_item(cau_pkg::OP_EQUAL, 32'h1, 32'h2, 32'h1, 32'h3, 0);
      send_item(cau_pkg::OP_LESS, 32'h8000_0000, 32'h5, 32'h7FFF_FFFF, 32'h0, 0);
      send_item(cau_pkg::OP_LESS, 32'h5, 32'h7, 32'h5, 32'h6, 0);
      send_item(4'd10, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      send_item(4'd15, 32'h1, 32'h1, 32'h1, 32'h1, 1);
      idle_gap();

      // random: mostly valid codes, a few unused; runs of back-to-back items
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                             : 4'($urandom_range(0, 9));
         ar = pick_operand();
         ai = pick_operand();
         br = pick_operand();
         bi = pick_operand();
         if ((op == cau_pkg::OP_EQUAL || op == cau_pkg::OP_LESS) &&
             $urandom_range(0, 1) == 1) begin
            br = ar;
            if ($urandom_range(0, 1) == 1) bi = ai;
         end
         if (op == cau_pkg::OP_DIV && $urandom_range(0, 9) == 0) begin
            br = '0;
            bi = '0;
         end
         gap = want_gap() || i == RANDOM_ITEMS - 1;
         send_item(op, ar, ai, br, bi, gap);
         if (gap) idle_gap();
      end

      // drain, then let the pipeline settle
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
